// File: hw/rtl/p2phc_pkg.sv
`timescale 1ns / 1ps

package p2phc_pkg;

	// Width of the byte position counter; the counter saturates at its top value
	localparam int POSITION_BITS = 20;
	// Walk targets need headroom for a 16-bit skip plus a dword skip
	localparam int TARGET_BITS   = POSITION_BITS + 2;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_MINIMUM = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_MAXIMUM = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAGS_MINIMUM   = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAGS_LIMIT     = 8'd3;

	// Register reset values
	localparam logic [15:0] LENGTH_MINIMUM_RST = 16'd30;
	localparam logic [15:0] LENGTH_MAXIMUM_RST = 16'd400;
	localparam logic [7:0]  TAGS_MINIMUM_RST   = 8'd2;
	localparam logic [7:0]  TAGS_LIMIT_RST     = 8'd6;

	// Packet constants
	localparam logic [7:0] MAGIC_BYTE       = 8'hE3;
	localparam logic [7:0] PKT_HELLO        = 8'h01;
	localparam logic [7:0] PKT_HELLO_ANSWER = 8'h4C;
	localparam logic [7:0] TAG_STRING       = 8'd2;
	localparam logic [7:0] TAG_DWORD        = 8'd3;
	localparam logic [7:0] TAG_FLOAT        = 8'd4;
	localparam int         COUNT_END_POS    = 30;
	localparam int         WALK_START_POS   = 31;

	typedef struct packed {
		logic [15:0] length_minimum;
		logic [15:0] length_maximum;
		logic [7:0]  tags_minimum;
		logic [7:0]  tags_limit;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic matched;
	} result_t;

endpackage

// File: hw/rtl/p2phc_if.sv
`timescale 1ns / 1ps

// Payload byte stream
interface p2phc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// Verdict stream
interface p2phc_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink   (input valid, input matched, output ready);
endinterface

// Register write channel
interface p2phc_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [p2phc_pkg::CFG_INDEX_BITS-1:0] index;
	logic [p2phc_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/p2p_hello_packet_classifier.sv
`timescale 1ns / 1ps

// Classifies hello and hello-answer packets of a peer-to-peer file-sharing protocol.
// Payload bytes enter on the payload channel, one transfer per byte, with last_byte
// on the final one; each packet yields exactly one verdict transfer (matched) at its
// last byte and nothing for the others. A byte is accepted each cycle while the
// verdict register is empty or being drained, and the verdict is registered and
// appears in the cycle after the last byte. Only a verdict left waiting on the
// verdict channel holds off the payload channel. The four limit registers (length
// minimum/maximum, tag count minimum and exclusive limit) are written through the
// cfg channel, which is always ready, and should only be changed between packets.

module p2p_hello_packet_classifier (
	input  logic                 clk,
	input  logic                 arst_n,
	p2phc_in_if.sink             payload,
	p2phc_out_if.source          verdict,
	p2phc_cfg_if.sink            cfg
);

	p2phc_pkg::cfg_t    cfg_q;
	p2phc_pkg::result_t result;
	logic               step;
	logic               verdict_valid_q;
	logic               matched_q;

	// Register file writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_minimum <= p2phc_pkg::LENGTH_MINIMUM_RST;
			cfg_q.length_maximum <= p2phc_pkg::LENGTH_MAXIMUM_RST;
			cfg_q.tags_minimum   <= p2phc_pkg::TAGS_MINIMUM_RST;
			cfg_q.tags_limit     <= p2phc_pkg::TAGS_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				p2phc_pkg::REG_LENGTH_MINIMUM: cfg_q.length_minimum <= cfg.data;
				p2phc_pkg::REG_LENGTH_MAXIMUM: cfg_q.length_maximum <= cfg.data;
				p2phc_pkg::REG_TAGS_MINIMUM:   cfg_q.tags_minimum   <= cfg.data[7:0];
				p2phc_pkg::REG_TAGS_LIMIT:     cfg_q.tags_limit     <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Byte acceptance
	assign payload.ready = !verdict_valid_q || verdict.ready;
	assign step          = payload.valid && payload.ready;

	p2phc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.payload_byte (payload.payload_byte),
		.last_byte    (payload.last_byte),
		.cfg          (cfg_q),
		.result       (result)
	);

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (payload.ready) begin
			verdict_valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.ready && result.valid) begin
			matched_q <= result.matched;
		end
	end

	assign verdict.valid   = verdict_valid_q;
	assign verdict.matched = matched_q;

	// Checks
	a_stall_only_on_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		!payload.ready |-> verdict_valid_q)
		else $error("payload stalled without a pending verdict");
	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(step && payload.last_byte) |=> verdict_valid_q)
		else $error("last byte gave no verdict");
	a_no_spurious_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(payload.ready && !(step && payload.last_byte)) |=> !verdict_valid_q)
		else $error("verdict without a last byte");

endmodule

// File: hw/rtl/p2phc_parser.sv
`timescale 1ns / 1ps

module p2phc_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             payload_byte,
	input  logic                   last_byte,
	input  p2phc_pkg::cfg_t        cfg,
	output p2phc_pkg::result_t     result
);

	localparam int PB = p2phc_pkg::POSITION_BITS;
	localparam int TB = p2phc_pkg::TARGET_BITS;

	// Parse phases
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_TAG_TYPE = 3'd1;
	localparam logic [2:0] PH_TAG_LEN0 = 3'd2;
	localparam logic [2:0] PH_TAG_LEN1 = 3'd3;
	localparam logic [2:0] PH_STR_LEN0 = 3'd4;
	localparam logic [2:0] PH_STR_LEN1 = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	logic [PB-1:0] pos_q,       pos_nx;
	logic [31:0]   len_word_q,  len_word_nx;
	logic [1:0]    shift_q,     shift_nx;
	logic          retried_q,   retried_nx;
	logic [31:0]   cnt_win_q,   cnt_win_nx;
	logic [2:0]    phase_q,     phase_nx;
	logic [PB-1:0] nfp_q,       nfp_nx;
	logic [7:0]    tags_left_q, tags_left_nx;
	logic [7:0]    held_low_q,  held_low_nx;
	logic [7:0]    tag_type_q,  tag_type_nx;
	logic          rej_q,       rej_nx;
	logic          ok;

	// Next state for one accepted byte
	always_comb begin
		logic [TB-1:0] tgt;
		logic          adv;
		logic [31:0]   len_full;
		logic [31:0]   win;
		logic [15:0]   skip;
		logic [7:0]    tl;

		pos_nx       = pos_q;
		len_word_nx  = len_word_q;
		shift_nx     = shift_q;
		retried_nx   = retried_q;
		cnt_win_nx   = cnt_win_q;
		phase_nx     = phase_q;
		nfp_nx       = nfp_q;
		tags_left_nx = tags_left_q;
		held_low_nx  = held_low_q;
		tag_type_nx  = tag_type_q;
		rej_nx       = rej_q;
		tgt          = '0;
		adv          = 1'b0;
		len_full     = {payload_byte, len_word_q[23:0]};
		win          = {payload_byte, cnt_win_q[31:8]};
		skip         = {payload_byte, held_low_q};
		tl           = tags_left_q - 8'd1;
		ok           = 1'b0;

		if (step) begin
			if (!rej_q) begin
				if (phase_q == PH_HEADER) begin
					if (pos_q == '0) begin
						if (payload_byte != p2phc_pkg::MAGIC_BYTE) rej_nx = 1'b1;
					end else if (pos_q <= PB'(4)) begin
						// little-endian length word, checked on its top byte
						case (pos_q[2:0])
							3'd1: len_word_nx[7:0]   = payload_byte;
							3'd2: len_word_nx[15:8]  = payload_byte;
							3'd3: len_word_nx[23:16] = payload_byte;
							default: begin
								len_word_nx[31:24] = payload_byte;
								if (len_full < {16'd0, cfg.length_minimum} ||
								    len_full > {16'd0, cfg.length_maximum})
									rej_nx = 1'b1;
							end
						endcase
					end else if (pos_q == PB'(5)) begin
						if (payload_byte == p2phc_pkg::PKT_HELLO) shift_nx = 2'd1;
						else if (payload_byte == p2phc_pkg::PKT_HELLO_ANSWER) shift_nx = 2'd0;
						else rej_nx = 1'b1;
					end else begin
						// tag count window; one retry one byte further on
						cnt_win_nx = win;
						if (pos_q == PB'(p2phc_pkg::COUNT_END_POS) + PB'(shift_q)) begin
							if (win >= {24'd0, cfg.tags_minimum} &&
							    win < {24'd0, cfg.tags_limit}) begin
								tags_left_nx = win[7:0];
								nfp_nx = PB'(p2phc_pkg::WALK_START_POS) + PB'(shift_q);
								phase_nx = (win[7:0] == 8'd0) ? PH_DONE : PH_TAG_TYPE;
							end else if (!retried_q) begin
								retried_nx = 1'b1;
								shift_nx   = shift_q + 2'd1;
							end else begin
								rej_nx = 1'b1;
							end
						end
					end
				end else if (pos_q == nfp_q) begin
					// tag walk: act only on the byte that opens the next field
					unique case (phase_q)
						PH_TAG_TYPE: begin
							tag_type_nx = payload_byte;
							if (payload_byte != p2phc_pkg::TAG_STRING &&
							    payload_byte != p2phc_pkg::TAG_DWORD &&
							    payload_byte != p2phc_pkg::TAG_FLOAT) begin
								rej_nx = 1'b1;
							end else begin
								adv      = 1'b1;
								tgt      = TB'(nfp_q) + TB'(1);
								phase_nx = PH_TAG_LEN0;
							end
						end
						PH_TAG_LEN0: begin
							held_low_nx = payload_byte;
							adv         = 1'b1;
							tgt         = TB'(nfp_q) + TB'(1);
							phase_nx    = PH_TAG_LEN1;
						end
						PH_TAG_LEN1: begin
							adv = 1'b1;
							if (tag_type_q == p2phc_pkg::TAG_STRING) begin
								tgt      = TB'(nfp_q) + TB'(1) + TB'(skip);
								phase_nx = PH_STR_LEN0;
							end else begin
								tgt          = TB'(nfp_q) + TB'(5) + TB'(skip);
								tags_left_nx = tl;
								phase_nx     = (tl == 8'd0) ? PH_DONE : PH_TAG_TYPE;
							end
						end
						PH_STR_LEN0: begin
							held_low_nx = payload_byte;
							adv         = 1'b1;
							tgt         = TB'(nfp_q) + TB'(1);
							phase_nx    = PH_STR_LEN1;
						end
						PH_STR_LEN1: begin
							adv          = 1'b1;
							tgt          = TB'(nfp_q) + TB'(1) + TB'(skip);
							tags_left_nx = tl;
							phase_nx     = (tl == 8'd0) ? PH_DONE : PH_TAG_TYPE;
						end
						default: ;
					endcase
					// a target beyond the position range rejects
					if (adv) begin
						if (tgt[TB-1:PB] != '0) rej_nx = 1'b1;
						else nfp_nx = tgt[PB-1:0];
					end
				end
			end

			if (last_byte) begin
				ok = !rej_nx && (phase_nx == PH_DONE) &&
				     ({1'b0, pos_q} + (PB+1)'(1) >= {1'b0, nfp_nx});
				pos_nx       = '0;
				len_word_nx  = '0;
				shift_nx     = '0;
				retried_nx   = 1'b0;
				cnt_win_nx   = '0;
				phase_nx     = PH_HEADER;
				nfp_nx       = '0;
				tags_left_nx = '0;
				held_low_nx  = '0;
				tag_type_nx  = '0;
				rej_nx       = 1'b0;
			end else if (pos_q != '1) begin
				pos_nx = pos_q + PB'(1);
			end
		end
	end

	// Per-packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			len_word_q  <= '0;
			shift_q     <= '0;
			retried_q   <= 1'b0;
			cnt_win_q   <= '0;
			phase_q     <= PH_HEADER;
			nfp_q       <= '0;
			tags_left_q <= '0;
			held_low_q  <= '0;
			tag_type_q  <= '0;
			rej_q       <= 1'b0;
		end else begin
			pos_q       <= pos_nx;
			len_word_q  <= len_word_nx;
			shift_q     <= shift_nx;
			retried_q   <= retried_nx;
			cnt_win_q   <= cnt_win_nx;
			phase_q     <= phase_nx;
			nfp_q       <= nfp_nx;
			tags_left_q <= tags_left_nx;
			held_low_q  <= held_low_nx;
			tag_type_q  <= tag_type_nx;
			rej_q       <= rej_nx;
		end
	end

	assign result.valid   = step && last_byte;
	assign result.matched = ok;

	// Checks
	a_done_no_tags: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> tags_left_q == 8'd0)
		else $error("done phase with tags outstanding");
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q != 2'd3)
		else $error("offset shift out of range");
	a_retry_shift: assert property (@(posedge clk) disable iff (!arst_n)
		retried_q |-> shift_q != 2'd0)
		else $error("retry without shift");
	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> (pos_q == '0 && phase_q == PH_HEADER && !rej_q))
		else $error("packet state not cleared after verdict");

endmodule
